### src/sct_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the serial character transposer ring
// no dependencies
package sct_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [1:0] {
		ACT_LINE   = 2'd0,
		ACT_GET    = 2'd1,
		ACT_PUT    = 2'd2,
		ACT_STATUS = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CLOSED   = 2'd1,
		ST_NO_DATA  = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRANSPOSITION = 3'd0,
		REG_DATA_BITS     = 3'd1,
		REG_REPLACE_CHAR  = 3'd2,
		REG_OUTPUT_EN     = 3'd3,
		REG_RING_LENGTH   = 3'd4
	} reg_idx_t;

	// receive parity modes
	localparam logic [1:0] RXP_KEEP = 2'd0;
	localparam logic [1:0] RXP_ODD  = 2'd1;
	localparam logic [1:0] RXP_EVEN = 2'd2;
	localparam logic [1:0] RXP_STRIP = 2'd3;

	// transmit parity modes
	localparam logic [1:0] TXP_NONE = 2'd0;
	localparam logic [1:0] TXP_ODD  = 2'd1;
	localparam logic [1:0] TXP_EVEN = 2'd2;

	// translation modes
	localparam logic [1:0] TR_PARTIAL = 2'd0;
	localparam logic [1:0] TR_FULL    = 2'd1;

	localparam logic [7:0] EOL_CODE   = 8'h9b;
	localparam logic [7:0] CR_CODE    = 8'h0d;
	localparam logic [7:0] LF_CODE    = 8'h0a;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_END  = 8'h7d;
	localparam logic [7:0] SEVEN_MASK = 8'h7f;

	localparam logic [3:0] BITS_MIN = 4'd5;
	localparam logic [3:0] BITS_MAX = 4'd8;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic               has_byte;
		logic [7:0]         out_byte;
		logic [1:0]         status_code;
		logic               parity_flag;
		logic               overrun_flag;
		logic [COUNT_W-1:0] buffered_count;
		logic               last;
	} rsp_t;

endpackage

### src/serial_char_transposer_ring.sv
`timescale 1ns / 1ps
// a taken request passes through the stage one register, then its result leaves the output register
// throughput: one request per cycle while the receiver does not stall; a put that expands
// to CR LF holds the intake while its second result goes out
// the ring memory read (one registered port) and the output register set the pace
// reset clears ring indices, fill count and sticky flags and restores the configuration
// defaults; ring contents stay undefined until written, so there is no clearing pass
module serial_char_transposer_ring
	import sct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// request channel
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	// result channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	// configuration registers
	logic [6:0]         transposition_q;
	logic [3:0]         data_bits_q;
	logic [7:0]         replace_char_q;
	logic               output_en_q;
	logic [COUNT_W-1:0] ring_length_q;

	// ring state, updated as each request is taken
	logic [7:0]         ring_mem [RING_DEPTH];
	logic [RING_AW-1:0] wr_idx_q;
	logic [RING_AW-1:0] rd_idx_q;
	logic [COUNT_W-1:0] fill_q;

	// sticky flags, updated as each result leaves stage one (keeps order with gets)
	logic               parity_q;
	logic               overrun_q;

	// stage one: the taken request plus the ring read data
	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [7:0]         byte_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               ovr_evt_s1;
	logic               empty_s1;
	logic [7:0]         rdata_s1;
	logic               phase_q;     // second result of a CR LF put pending

	// handshake
	logic               accept;
	logic               out_free;
	logic               emit;
	logic               release_s1;
	logic               need_two;

	// decode of the incoming request
	logic [COUNT_W-1:0] act_len;
	logic [COUNT_W-1:0] wr_next_w;
	logic [COUNT_W-1:0] rd_next_w;
	logic [RING_AW-1:0] wr_next;
	logic [RING_AW-1:0] rd_next;
	logic               ring_full;
	logic               do_write;
	logic               do_read;

	// stage two datapath
	logic [3:0]         act_bits;
	logic [7:0]         low_mask;
	logic [7:0]         par_mask;
	logic [1:0]         tr_mode;
	logic [7:0]         rx_byte;
	logic               rx_perr;
	logic               rx_pbit;
	logic               rx_odd;
	rsp_t               rsp_next;

	// odd number of ones among the data bits
	function automatic logic odd_ones(input logic [7:0] v, input logic [7:0] mask);
		odd_ones = ^(v & mask);
	endfunction

	// insert the transmit parity bit above the data bits
	function automatic logic [7:0] line_form(input logic [7:0] v, input logic [1:0] mode,
			input logic [3:0] bits, input logic [7:0] mask);
		logic [7:0] r;
		logic [7:0] pm;
		r  = v;
		pm = 8'(9'd1 << bits);
		if (mode != TXP_NONE) begin
			r = v | ~mask;
			if (mode == TXP_ODD && odd_ones(r, mask)) begin
				r = r & ~pm;
			end else if (mode == TXP_EVEN && !odd_ones(r, mask)) begin
				r = r & ~pm;
			end
		end
		line_form = r;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transposition_q <= '0;
			data_bits_q     <= BITS_MAX;
			replace_char_q  <= PRINT_LO;
			output_en_q     <= 1'b1;
			ring_length_q   <= COUNT_W'(RING_DEPTH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRANSPOSITION: transposition_q <= cfg_data[6:0];
				REG_DATA_BITS:     data_bits_q     <= cfg_data[3:0];
				REG_REPLACE_CHAR:  replace_char_q  <= cfg_data[7:0];
				REG_OUTPUT_EN:     output_en_q     <= cfg_data[0];
				REG_RING_LENGTH:   ring_length_q   <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage one moves on when the output register can take a result
	assign out_free   = !rsp_valid || !rsp_stall;
	assign emit       = valid_s1 && out_free;
	assign release_s1 = emit && !(need_two && !phase_q);
	assign cmd_stall  = valid_s1 && !release_s1;
	assign accept     = cmd_valid && !cmd_stall;

	// ring index arithmetic; an out-of-range length falls back to the full depth
	always_comb begin
		act_len = ring_length_q;
		if (ring_length_q < COUNT_W'(2) || ring_length_q > COUNT_W'(RING_DEPTH)) begin
			act_len = COUNT_W'(RING_DEPTH);
		end
		wr_next_w = COUNT_W'(wr_idx_q) + COUNT_W'(1);
		if (wr_next_w >= act_len) wr_next_w = '0;
		rd_next_w = COUNT_W'(rd_idx_q) + COUNT_W'(1);
		if (rd_next_w >= act_len) rd_next_w = '0;
		wr_next   = wr_next_w[RING_AW-1:0];
		rd_next   = rd_next_w[RING_AW-1:0];
		ring_full = (wr_next == rd_idx_q);
		do_write  = accept && cmd.action == ACT_LINE && !ring_full;
		do_read   = accept && cmd.action == ACT_GET && fill_q != '0;
	end

	// ring memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_mem[wr_next] <= cmd.data_byte;
		end
		if (do_read) begin
			rdata_s1 <= ring_mem[rd_next];
		end
	end

	// indices and fill count move with the request itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_write) begin
				wr_idx_q <= wr_next;
				if (fill_q < COUNT_W'(RING_DEPTH)) fill_q <= fill_q + COUNT_W'(1);
			end
			if (do_read) begin
				rd_idx_q <= rd_next;
				fill_q   <= fill_q - COUNT_W'(1);
			end
		end
	end

	// stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (release_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= cmd.action;
			byte_s1    <= cmd.data_byte;
			ovr_evt_s1 <= cmd.action == ACT_LINE && ring_full;
			empty_s1   <= fill_q == '0;
			// count after this request; only lines and gets move it
			if (do_write && fill_q < COUNT_W'(RING_DEPTH)) begin
				count_s1 <= fill_q + COUNT_W'(1);
			end else if (do_read) begin
				count_s1 <= fill_q - COUNT_W'(1);
			end else begin
				count_s1 <= fill_q;
			end
		end
	end

	// stage two: receive parity check, translation, transmit framing
	always_comb begin
		act_bits = data_bits_q;
		if (data_bits_q < BITS_MIN) act_bits = BITS_MIN;
		else if (data_bits_q > BITS_MAX) act_bits = BITS_MAX;
		low_mask = 8'((9'd1 << act_bits) - 9'd1);
		// no parity bit fits above eight data bits
		par_mask = 8'(9'd1 << act_bits);
		tr_mode  = transposition_q[5:4];

		rx_byte = rdata_s1;
		rx_pbit = |(rdata_s1 & par_mask);
		rx_odd  = odd_ones(rdata_s1, low_mask);
		rx_perr = 1'b0;
		unique case (transposition_q[3:2])
			RXP_ODD: begin
				rx_perr = (rx_odd == rx_pbit);
				rx_byte = rdata_s1 & ~par_mask;
			end
			RXP_EVEN: begin
				rx_perr = (rx_odd != rx_pbit);
				rx_byte = rdata_s1 & ~par_mask;
			end
			RXP_STRIP: rx_byte = rdata_s1 & ~par_mask;
			default: ;
		endcase
		if (tr_mode == TR_PARTIAL) begin
			if (rx_byte == CR_CODE) rx_byte = EOL_CODE;
		end else if (tr_mode == TR_FULL) begin
			if (rx_byte == CR_CODE) begin
				rx_byte = EOL_CODE;
			end else begin
				rx_byte = rx_byte & SEVEN_MASK;
				if (rx_byte < PRINT_LO || rx_byte >= PRINT_END) rx_byte = replace_char_q;
			end
		end

		need_two = action_s1 == ACT_PUT && output_en_q && byte_s1 == EOL_CODE
			&& tr_mode <= TR_FULL && transposition_q[6];

		rsp_next                = '0;
		rsp_next.status_code    = ST_OK;
		rsp_next.buffered_count = count_s1;
		rsp_next.parity_flag    = parity_q;
		rsp_next.overrun_flag   = overrun_q;
		rsp_next.last           = 1'b1;
		unique case (action_s1)
			ACT_LINE: rsp_next.overrun_flag = overrun_q | ovr_evt_s1;
			ACT_GET: begin
				if (empty_s1) begin
					rsp_next.status_code = ST_NO_DATA;
				end else begin
					rsp_next.has_byte    = 1'b1;
					rsp_next.out_byte    = rx_byte;
					rsp_next.parity_flag = parity_q | rx_perr;
				end
			end
			ACT_PUT: begin
				priority if (!output_en_q) begin
					rsp_next.status_code = ST_CLOSED;
				end else if (byte_s1 == EOL_CODE && tr_mode <= TR_FULL) begin
					// end of line goes out as CR, then LF when asked for
					rsp_next.has_byte = 1'b1;
					rsp_next.out_byte = line_form(phase_q ? LF_CODE : CR_CODE,
						transposition_q[1:0], act_bits, low_mask);
					rsp_next.last     = !need_two || phase_q;
				end else if (byte_s1 == EOL_CODE) begin
					rsp_next.has_byte = 1'b1;
					rsp_next.out_byte = line_form(EOL_CODE, transposition_q[1:0],
						act_bits, low_mask);
				end else if (tr_mode == TR_FULL
						&& (byte_s1 < PRINT_LO || byte_s1 >= PRINT_END)) begin
					// non-printable dropped in full translation
					rsp_next.has_byte = 1'b0;
				end else begin
					rsp_next.has_byte = 1'b1;
					rsp_next.out_byte = line_form(
						(tr_mode == TR_PARTIAL) ? (byte_s1 & SEVEN_MASK) : byte_s1,
						transposition_q[1:0], act_bits, low_mask);
				end
			end
			ACT_STATUS: ;  // report flags as they stand, cleared below
			default: ;
		endcase
	end

	// output register, phase of a two-result put, sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			phase_q   <= 1'b0;
			parity_q  <= 1'b0;
			overrun_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid <= 1'b1;
				phase_q   <= need_two && !phase_q;
				if (action_s1 == ACT_STATUS) begin
					parity_q  <= 1'b0;
					overrun_q <= 1'b0;
				end else begin
					parity_q  <= rsp_next.parity_flag;
					overrun_q <= rsp_next.overrun_flag;
				end
			end else if (out_free) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp <= rsp_next;
		end
	end

	// fill count never passes the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= COUNT_W'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	// the second half of a CR LF put follows straight after the first is taken
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |=> rsp_valid)
		else $error("second result of an end-of-line put missing");

	// a get on an empty ring leaves the read index alone
	a_empty_get: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.action == ACT_GET && fill_q == '0 |=> $stable(rd_idx_q))
		else $error("read index moved on an empty get");

	// a result without a byte carries a zero byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_byte |-> rsp.out_byte == 8'h00)
		else $error("byte present on a result without one");

endmodule

### bench/tb_serial_char_transposer_ring.sv
`timescale 1ns / 1ps
// self-checking bench for serial_char_transposer_ring: line, get, put and status requests
// run against an in-bench model of the ring, the parity rules and the character translation
// depends on src/sct_pkg.sv and src/serial_char_transposer_ring.sv
module tb_serial_char_transposer_ring;
	import sct_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] TR_NONE  = 2'd2;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int DRAIN_CYCLES     = 4;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_t                 cmd;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;

	serial_char_transposer_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the port: configuration and ring state as the bench believes them
	logic [6:0]          sh_transposition;
	logic [3:0]          sh_data_bits;
	logic [7:0]          sh_replace;
	logic                sh_out_en;
	logic [12:0]         sh_ring_len;
	logic [7:0]          sh_ring [RING_DEPTH];
	logic [RING_AW-1:0]  sh_wr_idx;
	logic [RING_AW-1:0]  sh_rd_idx;
	logic [COUNT_W-1:0]  sh_fill;
	logic                sh_parity_err;
	logic                sh_overrun;

	rsp_t pending_replies[$];
	int   errors = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;

	// ---------------------------------------------------------------
	// shadow model
	// ---------------------------------------------------------------

	function automatic int eff_bits();
		if (sh_data_bits < BITS_MIN) return int'(BITS_MIN);
		if (sh_data_bits > BITS_MAX) return int'(BITS_MAX);
		return int'(sh_data_bits);
	endfunction

	// ring lengths outside 2..RING_DEPTH fall back to the full ring
	function automatic int eff_len();
		if (sh_ring_len < 2 || sh_ring_len > RING_DEPTH) return RING_DEPTH;
		return int'(sh_ring_len);
	endfunction

	function automatic bit ones_odd(logic [7:0] v, int n);
		bit acc;
		int i;
		acc = 1'b0;
		for (i = 0; i < n; i++)
			acc ^= v[i];
		return acc;
	endfunction

	// transmit framing: force the bits above the character high, then clear
	// the parity bit where odd or even parity asks for it
	function automatic logic [7:0] tx_frame(logic [7:0] v);
		int n;
		logic [7:0] pm;
		logic [1:0] mode;
		n = eff_bits();
		pm = 8'((1 << n) & 'hff);
		mode = sh_transposition[1:0];
		if (mode != TXP_NONE) begin
			v = v | (8'hff << n);
			if (mode == TXP_ODD && ones_odd(v, n))
				v &= ~pm;
			else if (mode == TXP_EVEN && !ones_odd(v, n))
				v &= ~pm;
		end
		return v;
	endfunction

	function automatic void queue_reply(logic has, logic [7:0] ch, status_t code, logic fin);
		rsp_t r;
		r.has_byte       = has;
		r.out_byte       = ch;
		r.status_code    = code;
		r.parity_flag    = sh_parity_err;
		r.overrun_flag   = sh_overrun;
		r.buffered_count = sh_fill;
		r.last           = fin;
		pending_replies.push_back(r);
	endfunction

	// advance the shadow by one accepted request and queue its replies
	function automatic void port_response(action_t act, logic [7:0] din);
		int len, nxt, n;
		logic [1:0] tr;
		logic [7:0] d, pm;
		bit pbit;
		len = eff_len();
		tr = sh_transposition[5:4];
		case (act)
			ACT_LINE: begin
				nxt = int'(sh_wr_idx) + 1;
				if (nxt >= len) nxt = 0;
				if (nxt == int'(sh_rd_idx)) begin
					sh_overrun = 1'b1;
				end else begin
					sh_ring[nxt] = din;
					sh_wr_idx = RING_AW'(nxt);
					if (sh_fill < RING_DEPTH) sh_fill++;
				end
				queue_reply(1'b0, 8'h00, ST_OK, 1'b1);
			end
			ACT_GET: begin
				if (sh_fill == 0) begin
					queue_reply(1'b0, 8'h00, ST_NO_DATA, 1'b1);
				end else begin
					n = eff_bits();
					pm = 8'((1 << n) & 'hff);
					nxt = int'(sh_rd_idx) + 1;
					if (nxt >= len) nxt = 0;
					d = sh_ring[nxt];
					sh_rd_idx = RING_AW'(nxt);
					sh_fill--;
					pbit = (d & pm) != 0;
					case (sh_transposition[3:2])
						RXP_ODD: begin
							if (ones_odd(d, n) == pbit) sh_parity_err = 1'b1;
							d &= ~pm;
						end
						RXP_EVEN: begin
							if (ones_odd(d, n) != pbit) sh_parity_err = 1'b1;
							d &= ~pm;
						end
						RXP_STRIP: d &= ~pm;
						default: ;
					endcase
					if (tr == TR_PARTIAL) begin
						if (d == CR_CODE) d = EOL_CODE;
					end else if (tr == TR_FULL) begin
						if (d == CR_CODE) begin
							d = EOL_CODE;
						end else begin
							d &= SEVEN_MASK;
							if (d < PRINT_LO || d >= PRINT_END) d = sh_replace;
						end
					end
					queue_reply(1'b1, d, ST_OK, 1'b1);
				end
			end
			ACT_PUT: begin
				if (!sh_out_en) begin
					queue_reply(1'b0, 8'h00, ST_CLOSED, 1'b1);
				end else if (din == EOL_CODE && tr <= TR_FULL) begin
					// end of line goes out as CR, optionally followed by LF
					queue_reply(1'b1, tx_frame(CR_CODE), ST_OK, !sh_transposition[6]);
					if (sh_transposition[6])
						queue_reply(1'b1, tx_frame(LF_CODE), ST_OK, 1'b1);
				end else if (din == EOL_CODE) begin
					queue_reply(1'b1, tx_frame(EOL_CODE), ST_OK, 1'b1);
				end else if (tr == TR_FULL && (din < PRINT_LO || din >= PRINT_END)) begin
					// non-printable dropped in full translation
					queue_reply(1'b0, 8'h00, ST_OK, 1'b1);
				end else begin
					if (tr == TR_PARTIAL) din &= SEVEN_MASK;
					queue_reply(1'b1, tx_frame(din), ST_OK, 1'b1);
				end
			end
			default: begin
				// status read reports the flags before clearing them
				queue_reply(1'b0, 8'h00, ST_OK, 1'b1);
				sh_parity_err = 1'b0;
				sh_overrun = 1'b0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// driving
	// ---------------------------------------------------------------

	// must be entered just after a rising edge; valid stays high on return so
	// that back-to-back requests never see it lowered and raised in one step
	task automatic send_request(action_t act, logic [7:0] din);
		cmd_valid <= 1'b1;
		cmd.action <= act;
		cmd.data_byte <= din;
		do
			@(posedge clk);
		while (cmd_stall);
		port_response(act, din);
	endtask

	// sender bursts with random gaps, some bursts run straight into the next
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	// hold the sender until every reply is back and the pipeline has emptied
	task automatic quiesce();
		cmd_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// empty the ring so that a new ring length never exposes an unwritten slot
	task automatic drain_ring();
		while (sh_fill != 0) begin
			pace_sender();
			send_request(ACT_GET, 8'($urandom));
		end
		quiesce();
	endtask

	// the enable drops for a cycle after each write so that back-to-back
	// writes never drive it twice in one step
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TRANSPOSITION: sh_transposition = v[6:0];
			REG_DATA_BITS:     sh_data_bits = v[3:0];
			REG_REPLACE_CHAR:  sh_replace = v[7:0];
			REG_OUTPUT_EN:     sh_out_en = v[0];
			REG_RING_LENGTH:   sh_ring_len = v[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// mostly random bytes, now and then one of the characters the rules single out
	function automatic logic [7:0] pick_char();
		logic [7:0] marked [10] = '{EOL_CODE, CR_CODE, LF_CODE, 8'h1f, PRINT_LO,
			8'h7c, PRINT_END, SEVEN_MASK, 8'h80, 8'h8d};
		if ($urandom_range(0, 3) == 0)
			return marked[$urandom_range(0, 9)];
		return 8'($urandom);
	endfunction

	function automatic action_t pick_action(int line_pct, int get_pct, int put_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < line_pct) return ACT_LINE;
		if (r < line_pct + get_pct) return ACT_GET;
		if (r < line_pct + get_pct + put_pct) return ACT_PUT;
		return ACT_STATUS;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// extremes, every request kind and each corner of the rules, by hand
	task automatic test_directed();
		// reset settings: no parity, keep, partial translation, 8 bits, full ring
		send_request(ACT_STATUS, 8'h00);
		send_request(ACT_GET, 8'hff);               // empty ring
		send_request(ACT_PUT, EOL_CODE);            // end of line becomes CR
		send_request(ACT_PUT, 8'hff);               // partial mode drops bit 7
		send_request(ACT_LINE, CR_CODE);
		send_request(ACT_LINE, 8'hff);
		send_request(ACT_LINE, 8'h00);
		send_request(ACT_GET, 8'h00);               // CR reads back as end of line
		send_request(ACT_GET, 8'h00);               // eight bits: nothing stripped
		send_request(ACT_GET, 8'h00);
		quiesce();

		// full translation with CR LF, odd receive check, even transmit parity
		write_reg(REG_TRANSPOSITION, {6'd0, 1'b1, TR_FULL, RXP_ODD, TXP_EVEN});
		write_reg(REG_DATA_BITS, 13'd7);
		write_reg(REG_REPLACE_CHAR, 13'hff);
		send_request(ACT_PUT, EOL_CODE);            // two replies
		send_request(ACT_PUT, 8'h1f);               // dropped
		send_request(ACT_PUT, PRINT_END);           // dropped
		send_request(ACT_PUT, 8'h7c);
		send_request(ACT_LINE, 8'h8d);
		send_request(ACT_LINE, 8'h01);
		send_request(ACT_GET, 8'h00);
		send_request(ACT_GET, 8'h00);               // control char gets the replacement
		send_request(ACT_STATUS, 8'h00);
		quiesce();

		// output closed; out-of-range width and ring length
		write_reg(REG_OUTPUT_EN, 13'd0);
		write_reg(REG_DATA_BITS, 13'd4);
		write_reg(REG_RING_LENGTH, 13'd1);
		send_request(ACT_PUT, EOL_CODE);
		quiesce();

		write_reg(REG_OUTPUT_EN, 13'd1);
		write_reg(REG_DATA_BITS, 13'd15);
		write_reg(REG_TRANSPOSITION, {6'd0, 1'b1, TR_NONE, RXP_STRIP, TXP_ODD});
		write_reg(REG_REPLACE_CHAR, 13'd0);
		write_reg(REG_RING_LENGTH, 13'd2);
		send_request(ACT_PUT, EOL_CODE);            // untranslated end of line
		send_request(ACT_LINE, 8'h55);
		send_request(ACT_LINE, 8'haa);              // indices sit past the new length: both land
		send_request(ACT_STATUS, 8'h00);
		send_request(ACT_GET, 8'h00);
		quiesce();
	endtask

	// tiny rings filled past capacity to exercise wrap and overrun
	task automatic test_overrun_small_rings();
		int lens [4] = '{2, 3, 5, 8};
		int k, i;
		for (k = 0; k < 4; k++) begin
			drain_ring();
			write_reg(REG_RING_LENGTH, CFG_W'(lens[k]));
			write_reg(REG_TRANSPOSITION, CFG_W'($urandom_range(0, 127)));
			for (i = 0; i < 40; i++) begin
				pace_sender();
				send_request(pick_action(60, 25, 5), pick_char());
			end
		end
		drain_ring();
		write_reg(REG_RING_LENGTH, 13'h1fff);       // out of range: full ring again
	endtask

	// phases of random settings, extremes first, random mixed traffic in each
	task automatic test_random_phases();
		int lens [8] = '{2, 4, 16, 4096, 0, 1, 4097, 333};
		int ph, i;
		logic [CFG_W-1:0] ring_len;
		for (ph = 0; ph < 8; ph++) begin
			drain_ring();
			if (ph == 0) begin
				write_reg(REG_TRANSPOSITION, 13'd127);
				write_reg(REG_DATA_BITS, 13'd5);
				write_reg(REG_REPLACE_CHAR, 13'hff);
				write_reg(REG_OUTPUT_EN, 13'd1);
				write_reg(REG_RING_LENGTH, 13'd4096);
			end else if (ph == 1) begin
				write_reg(REG_TRANSPOSITION, 13'd0);
				write_reg(REG_DATA_BITS, 13'd8);
				write_reg(REG_REPLACE_CHAR, 13'd0);
				write_reg(REG_OUTPUT_EN, 13'd1);
				write_reg(REG_RING_LENGTH, 13'd2);
			end else begin
				write_reg(REG_TRANSPOSITION, CFG_W'($urandom_range(0, 127)));
				write_reg(REG_DATA_BITS, ($urandom_range(0, 3) == 0) ?
					CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(5, 8)));
				write_reg(REG_REPLACE_CHAR, CFG_W'($urandom_range(0, 255)));
				write_reg(REG_OUTPUT_EN, CFG_W'($urandom_range(0, 5) != 0));
				ring_len = ($urandom_range(0, 2) == 0) ?
					CFG_W'($urandom_range(2, 4096)) : CFG_W'(lens[$urandom_range(0, 7)]);
				write_reg(REG_RING_LENGTH, ring_len);
			end
			for (i = 0; i < 55; i++) begin
				pace_sender();
				send_request(pick_action(35, 35, 20), pick_char());
			end
		end
	endtask

	// ---------------------------------------------------------------
	// receiver stall pattern: changes character every so often
	// ---------------------------------------------------------------
	int stall_mode = 0;
	int mode_left = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(16, 160);
		end
		mode_left--;
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ((mode_left % 8) < 3);
		endcase
	end

	// ---------------------------------------------------------------
	// reply checker
	// ---------------------------------------------------------------
	task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				$error("reply with nothing outstanding: 0x%0h", rsp);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				cmp_field("has_byte", 16'(want.has_byte), 16'(rsp.has_byte));
				cmp_field("out_byte", 16'(want.out_byte), 16'(rsp.out_byte));
				cmp_field("status_code", 16'(want.status_code), 16'(rsp.status_code));
				cmp_field("parity_flag", 16'(want.parity_flag), 16'(rsp.parity_flag));
				cmp_field("overrun_flag", 16'(want.overrun_flag), 16'(rsp.overrun_flag));
				cmp_field("buffered_count", 16'(want.buffered_count),
					16'(rsp.buffered_count));
				cmp_field("last", 16'(want.last), 16'(rsp.last));
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: too long without any handshake or register write
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("serial_char_transposer_ring test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b0;

		// shadow starts from the reset settings
		sh_transposition = '0;
		sh_data_bits = 4'd8;
		sh_replace = PRINT_LO;
		sh_out_en = 1'b1;
		sh_ring_len = 13'(RING_DEPTH);
		sh_wr_idx = '0;
		sh_rd_idx = '0;
		sh_fill = '0;
		sh_parity_err = 1'b0;
		sh_overrun = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overrun_small_rings();
		test_random_phases();

		// all requests in: wait out the replies, then the pipeline tail
		quiesce();
		repeat (8) @(posedge clk);
		if (pending_replies.size() != 0) begin
			$error("%0d replies never arrived", pending_replies.size());
			errors++;
		end
		if (errors == 0)
			$display("serial_char_transposer_ring test passed");
		else
			$display("serial_char_transposer_ring test failed");
		$finish;
	end

endmodule
